/* rtl/uxf_pkg.sv */
// uxf_pkg: shared types and constants of the uart fifo xon/xoff flow unit
// used by uxf_ctrl and uart_fifo_xon_xoff_flow_unit

package uxf_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam logic [7:0] CODE_XON  = 8'h11;
   localparam logic [7:0] CODE_XOFF = 8'h13;

   localparam logic [7:0] XOFF_THR_RESET = 8'd16;
   localparam logic [7:0] XON_THR_RESET  = 8'd8;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic [1:0] {
      FUNC_LINE_RX = 2'd0,
      FUNC_TX_TICK = 2'd1,
      FUNC_HOST_WR = 2'd2,
      FUNC_HOST_RD = 2'd3
   } func_type;

   typedef enum logic [0:0] {
      REG_XOFF_THR = 1'b0,
      REG_XON_THR  = 1'b1
   } reg_idx_type;

   // per-beat result as decided at accept time; memory data joins when the beat leaves the middle stage
   typedef struct packed {
      logic       line_valid;
      logic       line_from_mem;
      logic [7:0] line_code;
      logic       read_valid;
      logic       accepted;
      logic [7:0] rx_fill;
      logic [7:0] tx_space;
      logic       remote_stopped;
      logic       tx_armed;
   } res_type;

endpackage

/* rtl/uxf_ram.sv */
// uxf_ram: byte-wide synchronous ring store, one write and one read port
// read data registered; no dependencies

module uxf_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/uxf_ctrl.sv */
// uxf_ctrl: ring pointers, xon/xoff flags and per-beat decisions
// drives both uxf_ram ports; depends on uxf_pkg

module uxf_ctrl
   import uxf_pkg::*;
#(
   parameter int FIFO_DEPTH = DEPTH_DEFAULT,
   parameter int PTR_W      = $clog2(FIFO_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  func_type         func,
   input  logic [7:0]       data_byte,
   input  logic             last_of_message,
   input  logic [7:0]       xoff_thr,
   input  logic [7:0]       xon_thr,
   output logic             rx_wr_en,
   output logic [PTR_W-1:0] rx_wr_addr,
   output logic             rx_rd_en,
   output logic [PTR_W-1:0] rx_rd_addr,
   output logic             tx_wr_en,
   output logic [PTR_W-1:0] tx_wr_addr,
   output logic             tx_rd_en,
   output logic [PTR_W-1:0] tx_rd_addr,
   output logic [7:0]       wr_data,
   output res_type          res
);

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(FIFO_DEPTH);

   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic             pending_ff, pending_in, held_ff, held_in, enable_ff, enable_in;
   logic [PTR_W-1:0] rx_used, tx_used, rx_used_new, tx_used_new;
   logic [PTR_W-1:0] rx_free_new, tx_free_new;

   function automatic logic [PTR_W-1:0] ring_used(input logic [PTR_W-1:0] head,
                                                  input logic [PTR_W-1:0] tail);
      logic [PTR_W:0] diff;
      diff = {1'b0, head} - {1'b0, tail};
      if (head < tail) begin
         diff = diff + DEPTH_EXT;
      end
      return diff[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign rx_used    = ring_used(rx_head_ff, rx_tail_ff);
   assign tx_used    = ring_used(tx_head_ff, tx_tail_ff);
   assign rx_wr_addr = rx_head_ff;
   assign rx_rd_addr = rx_tail_ff;
   assign tx_wr_addr = tx_head_ff;
   assign tx_rd_addr = tx_tail_ff;
   assign wr_data    = data_byte;

   always_comb begin
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      pending_in  = pending_ff;
      held_in     = held_ff;
      enable_in   = enable_ff;
      rx_used_new = rx_used;
      tx_used_new = tx_used;
      rx_wr_en    = 1'b0;
      rx_rd_en    = 1'b0;
      tx_wr_en    = 1'b0;
      tx_rd_en    = 1'b0;
      res         = '0;
      if (fire) begin
         case (func)
            FUNC_LINE_RX: begin
               if (rx_used != LAST_SLOT) begin
                  rx_wr_en     = 1'b1;
                  rx_head_in   = ring_next(rx_head_ff);
                  rx_used_new  = rx_used + 1'b1;
                  res.accepted = 1'b1;
               end
               if (8'(LAST_SLOT - rx_used_new) < xoff_thr && !held_ff) begin
                  pending_in = 1'b1;
                  enable_in  = 1'b1;
               end
            end
            FUNC_TX_TICK: begin
               if (enable_ff) begin
                  if (pending_ff && !held_ff) begin
                     res.line_valid = 1'b1;
                     res.line_code  = CODE_XOFF;
                     pending_in     = 1'b0;
                     held_in        = 1'b1;
                  end else if (held_ff && 8'(rx_used) < xon_thr) begin
                     res.line_valid = 1'b1;
                     res.line_code  = CODE_XON;
                     held_in        = 1'b0;
                  end else if (tx_used != '0) begin
                     res.line_valid    = 1'b1;
                     res.line_from_mem = 1'b1;
                     tx_rd_en          = 1'b1;
                     tx_tail_in        = ring_next(tx_tail_ff);
                     tx_used_new       = tx_used - 1'b1;
                  end else begin
                     enable_in = 1'b0;
                  end
               end
            end
            FUNC_HOST_WR: begin
               if (tx_used != LAST_SLOT) begin
                  tx_wr_en     = 1'b1;
                  tx_head_in   = ring_next(tx_head_ff);
                  tx_used_new  = tx_used + 1'b1;
                  res.accepted = 1'b1;
               end
               if (last_of_message) begin
                  enable_in = 1'b1;
               end
            end
            default: begin
               if (rx_used != '0) begin
                  rx_rd_en       = 1'b1;
                  rx_tail_in     = ring_next(rx_tail_ff);
                  rx_used_new    = rx_used - 1'b1;
                  res.read_valid = 1'b1;
               end
               if (held_ff && 8'(rx_used_new) < xon_thr) begin
                  enable_in = 1'b1;
               end
            end
         endcase
      end
      rx_free_new        = LAST_SLOT - rx_used_new;
      tx_free_new        = LAST_SLOT - tx_used_new;
      res.rx_fill        = 8'(rx_used_new);
      res.tx_space       = 8'(tx_free_new);
      res.remote_stopped = held_in;
      res.tx_armed       = enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         pending_ff <= 1'b0;
         held_ff    <= 1'b0;
         enable_ff  <= 1'b0;
      end else begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
         enable_ff  <= enable_in;
      end
   end

   // xoff is only queued while not held, and sending it clears the queue
   assert property (@(posedge clock) disable iff (reset) !(pending_ff && held_ff))
      else $error("xoff queued while already held");

   // a sent xoff leaves the remote held and the transmitter armed
   assert property (@(posedge clock) disable iff (reset)
      (fire && res.line_valid && !res.line_from_mem && res.line_code == CODE_XOFF)
      |=> (held_ff && enable_ff))
      else $error("xoff sent without holding the remote");

   // a store pop only happens from a non-empty ring
   assert property (@(posedge clock) disable iff (reset)
      (!tx_rd_en || tx_head_ff != tx_tail_ff) && (!rx_rd_en || rx_head_ff != rx_tail_ff))
      else $error("pop from an empty ring");

   assert property (@(posedge clock) disable iff (reset)
      rx_free_new <= LAST_SLOT && rx_head_ff <= LAST_SLOT && tx_head_ff <= LAST_SLOT)
      else $error("ring pointer out of range");

endmodule

/* rtl/uart_fifo_xon_xoff_flow_unit.sv */
// uart_fifo_xon_xoff_flow_unit: top level with csr port, two byte rings and result stage
// depends on uxf_pkg, uxf_ctrl and uxf_ram
//
// Usage:
// - req channel: one beat per event, req_func selects line byte received, transmitter
//   tick, host write (req_last_of_message arms the transmitter) or host read.
// - rsp channel: exactly one beat per req beat, in order: line byte sent, host read
//   byte, push status, receive fill, transmit space, xoff-held and armed flags.
// - csr port: register 0 (address 0) is the xoff free-space threshold, register 1
//   (address 4) the xon fill threshold; bits 7:0 of the data, readable back.
// Pipeline: a req beat passes the middle stage and then the rsp register, the middle
//   stage covering the registered read of the receive or transmit ring memory.
// Throughput: one req beat per cycle while req_ready is high; pointers and flags update
//   at the accepting edge, so each beat sees the ring state left by the one before.
// Reset: pointers and flags clear, thresholds return to 16 and 8; the ring memories
//   are not cleared and no entry is read before it has been written.
// Stall: a beat waits in the middle stage while rsp_ready is low; once both the
//   middle stage and the rsp register are full, req_ready drops.

module uart_fifo_xon_xoff_flow_unit
   import uxf_pkg::*;
#(
   parameter int FIFO_DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_of_message,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_line_valid,
   output logic [7:0]            rsp_line_byte,
   output logic                  rsp_read_valid,
   output logic [7:0]            rsp_read_byte,
   output logic                  rsp_accepted,
   output logic [7:0]            rsp_rx_fill,
   output logic [7:0]            rsp_tx_space,
   output logic                  rsp_remote_stopped,
   output logic                  rsp_tx_armed,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic             fire, s1_move;
   logic             s1_valid_ff;
   res_type          s1_res_ff, res;
   logic             rsp_valid_ff;
   res_type          rsp_res_ff;
   logic [7:0]       rsp_line_byte_ff, rsp_read_byte_ff;
   logic [7:0]       xoff_thr_ff, xon_thr_ff;
   logic             csr_wr;
   reg_idx_type      csr_idx;
   logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [PTR_W-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
   logic [7:0]       wr_data, rx_rd_data, tx_rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         xoff_thr_ff <= XOFF_THR_RESET;
         xon_thr_ff  <= XON_THR_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_XOFF_THR: xoff_thr_ff <= csr_pwdata[7:0];
            REG_XON_THR:  xon_thr_ff  <= csr_pwdata[7:0];
            default:      xon_thr_ff  <= xon_thr_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_XOFF_THR: csr_prdata = {24'd0, xoff_thr_ff};
         REG_XON_THR:  csr_prdata = {24'd0, xon_thr_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign s1_move   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign fire      = req_valid && req_ready;

   uxf_ctrl #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .PTR_W      (PTR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .func            (func_type'(req_func)),
      .data_byte       (req_data_byte),
      .last_of_message (req_last_of_message),
      .xoff_thr        (xoff_thr_ff),
      .xon_thr         (xon_thr_ff),
      .rx_wr_en        (rx_wr_en),
      .rx_wr_addr      (rx_wr_addr),
      .rx_rd_en        (rx_rd_en),
      .rx_rd_addr      (rx_rd_addr),
      .tx_wr_en        (tx_wr_en),
      .tx_wr_addr      (tx_wr_addr),
      .tx_rd_en        (tx_rd_en),
      .tx_rd_addr      (tx_rd_addr),
      .wr_data         (wr_data),
      .res             (res)
   );

   uxf_ram #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   uxf_ram #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // middle stage waits for the ring read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= fire;
         end
         if (s1_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      if (fire) begin
         s1_res_ff <= res;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_res_ff       <= s1_res_ff;
         rsp_line_byte_ff <= !s1_res_ff.line_valid ? 8'd0
                             : s1_res_ff.line_from_mem ? tx_rd_data : s1_res_ff.line_code;
         rsp_read_byte_ff <= s1_res_ff.read_valid ? rx_rd_data : 8'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_valid     = rsp_res_ff.line_valid;
   assign rsp_line_byte      = rsp_line_byte_ff;
   assign rsp_read_valid     = rsp_res_ff.read_valid;
   assign rsp_read_byte      = rsp_read_byte_ff;
   assign rsp_accepted       = rsp_res_ff.accepted;
   assign rsp_rx_fill        = rsp_res_ff.rx_fill;
   assign rsp_tx_space       = rsp_res_ff.tx_space;
   assign rsp_remote_stopped = rsp_res_ff.remote_stopped;
   assign rsp_tx_armed       = rsp_res_ff.tx_armed;

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for uart_fifo_xon_xoff_flow_unit, receive/transmit rings and
// xon/xoff pacing checked beat by beat against an in-bench flow predictor
// depends on uxf_pkg and the rtl of uart_fifo_xon_xoff_flow_unit
`timescale 1ns / 1ps

module tb_top;
   import uxf_pkg::*;

   typedef struct packed {
      logic       line_valid;
      logic [7:0] line_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       accepted;
      logic [7:0] rx_fill;
      logic [7:0] tx_space;
      logic       remote_stopped;
      logic       tx_armed;
   } flow_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = FUNC_LINE_RX;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_last_of_message = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_line_valid;
   logic [7:0]            rsp_line_byte;
   logic                  rsp_read_valid;
   logic [7:0]            rsp_read_byte;
   logic                  rsp_accepted;
   logic [7:0]            rsp_rx_fill;
   logic [7:0]            rsp_tx_space;
   logic                  rsp_remote_stopped;
   logic                  rsp_tx_armed;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   uart_fifo_xon_xoff_flow_unit DUT (.*);

   // predictor state, rings of 256 slots so 8 bit pointers wrap on their own
   logic [7:0] rx_ring [256];
   logic [7:0] tx_ring [256];
   logic [7:0] rx_wr = '0, rx_rd = '0, tx_wr = '0, tx_rd = '0;
   logic       xoff_due = 1'b0, remote_held = 1'b0, tx_on = 1'b0;
   logic [7:0] xoff_thr = XOFF_THR_RESET, xon_thr = XON_THR_RESET;

   flow_result_type pending_results[$];
   int fault_count = 0;
   int burst_left = 0;
   int calm_left = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [7:0] rx_used();
      return rx_wr - rx_rd;
   endfunction

   function automatic logic [7:0] tx_used();
      return tx_wr - tx_rd;
   endfunction

   function automatic flow_result_type apply_event(func_type f, logic [7:0] data, logic last);
      flow_result_type r;
      r = '0;
      case (f)
         FUNC_LINE_RX: begin
            if (rx_used() != 8'd255) begin
               rx_ring[rx_wr] = data;
               rx_wr++;
               r.accepted = 1'b1;
            end
            if ((8'd255 - rx_used()) < xoff_thr && !remote_held) begin
               xoff_due = 1'b1;
               tx_on = 1'b1;
            end
         end
         FUNC_TX_TICK: begin
            if (tx_on) begin
               if (xoff_due && !remote_held) begin
                  r.line_valid = 1'b1;
                  r.line_byte = CODE_XOFF;
                  xoff_due = 1'b0;
                  remote_held = 1'b1;
               end else if (remote_held && rx_used() < xon_thr) begin
                  r.line_valid = 1'b1;
                  r.line_byte = CODE_XON;
                  remote_held = 1'b0;
               end else if (tx_wr != tx_rd) begin
                  r.line_valid = 1'b1;
                  r.line_byte = tx_ring[tx_rd];
                  tx_rd++;
               end else begin
                  tx_on = 1'b0;
               end
            end
         end
         FUNC_HOST_WR: begin
            if (tx_used() != 8'd255) begin
               tx_ring[tx_wr] = data;
               tx_wr++;
               r.accepted = 1'b1;
            end
            if (last) tx_on = 1'b1;
         end
         default: begin
            if (rx_wr != rx_rd) begin
               r.read_valid = 1'b1;
               r.read_byte = rx_ring[rx_rd];
               rx_rd++;
            end
            if (remote_held && rx_used() < xon_thr) tx_on = 1'b1;
         end
      endcase
      r.rx_fill = rx_used();
      r.tx_space = 8'd255 - tx_used();
      r.remote_stopped = remote_held;
      r.tx_armed = tx_on;
      return r;
   endfunction

   function automatic string fmt_result(flow_result_type r);
      return $sformatf("line %0b/%02h read %0b/%02h acc %0b fill %0d space %0d stop %0b arm %0b",
                       r.line_valid, r.line_byte, r.read_valid, r.read_byte, r.accepted,
                       r.rx_fill, r.tx_space, r.remote_stopped, r.tx_armed);
   endfunction

   task automatic report_fault(string what);
      if (fault_count < 10) $display("%0t: %s", $realtime, what);
      fault_count++;
   endtask

   // sender: bursts of random length, random gaps between them
   task automatic send_event(func_type f, logic [7:0] data, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= f;
      req_data_byte <= data;
      req_last_of_message <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_event(f, data, last));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(reg_idx_type idx, logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_XOFF_THR: xoff_thr = value;
         default:      xon_thr = value;
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[7:0] !== value)
         report_fault($sformatf("register %0d read back %02h, wrote %02h",
                                idx, csr_prdata[7:0], value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_thresholds(logic [7:0] xoff, logic [7:0] xon);
      wait_drained();
      write_register(REG_XOFF_THR, xoff);
      write_register(REG_XON_THR, xon);
   endtask

   task automatic test_basic_paths();
      send_event(FUNC_TX_TICK, 8'h00, 1'b0);
      send_event(FUNC_HOST_RD, 8'hFF, 1'b1);
      send_event(FUNC_HOST_WR, 8'h00, 1'b0);
      send_event(FUNC_HOST_WR, 8'hFF, 1'b1);
      send_event(FUNC_HOST_WR, 8'h5A, 1'b0);
      repeat (4) send_event(FUNC_TX_TICK, 8'hA5, 1'b1);
      send_event(FUNC_TX_TICK, 8'h00, 1'b0);
      send_event(FUNC_LINE_RX, 8'h00, 1'b0);
      send_event(FUNC_LINE_RX, 8'hFF, 1'b1);
      repeat (3) send_event(FUNC_HOST_RD, 8'h00, 1'b0);
   endtask

   task automatic test_xoff_xon_cycle();
      set_thresholds(8'd255, 8'd2);
      send_event(FUNC_LINE_RX, 8'hA5, 1'b0);
      send_event(FUNC_LINE_RX, 8'h3C, 1'b0);
      send_event(FUNC_TX_TICK, 8'h00, 1'b0);
      send_event(FUNC_LINE_RX, 8'h81, 1'b0);
      send_event(FUNC_TX_TICK, 8'h00, 1'b0);
      send_event(FUNC_HOST_RD, 8'h00, 1'b0);
      send_event(FUNC_HOST_RD, 8'h00, 1'b0);
      send_event(FUNC_TX_TICK, 8'h00, 1'b0);
      send_event(FUNC_TX_TICK, 8'h00, 1'b0);
      send_event(FUNC_HOST_RD, 8'h00, 1'b0);
   endtask

   task automatic test_rx_overflow();
      set_thresholds(XOFF_THR_RESET, XON_THR_RESET);
      for (int i = 0; i < 257; i++) begin
         send_event(FUNC_LINE_RX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         if (i % 32 == 31) send_event(FUNC_TX_TICK, 8'($urandom_range(0, 255)), 1'b0);
      end
      for (int i = 0; i < 8; i++)
         send_event(FUNC_HOST_RD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_tx_overflow();
      for (int i = 0; i < 257; i++)
         send_event(FUNC_HOST_WR, 8'($urandom_range(0, 255)), i == 256);
      for (int i = 0; i < 8; i++)
         send_event(FUNC_TX_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_traffic_phase(int count, logic [7:0] xoff, logic [7:0] xon);
      int w_line, w_read, w_tick, pick;
      func_type f;
      set_thresholds(xoff, xon);
      w_line = $urandom_range(25, 50);
      w_read = $urandom_range(10, 30);
      w_tick = $urandom_range(10, 20);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < w_line) f = FUNC_LINE_RX;
         else if (pick < w_line + w_read) f = FUNC_HOST_RD;
         else if (pick < w_line + w_read + w_tick) f = FUNC_TX_TICK;
         else f = FUNC_HOST_WR;
         send_event(f, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(6, 8'd255, 8'd255);
      run_traffic_phase(6, 8'd255, 8'd0);
      run_traffic_phase(6, 8'd0, 8'd255);
      run_traffic_phase(6, 8'($urandom_range(224, 254)), 8'($urandom_range(1, 32)));
   endtask

   // receiver: short stalls at random, now and then a long stretch without any
   always @(posedge clock) begin
      if (calm_left != 0) begin
         calm_left <= calm_left - 1;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         case ($urandom_range(0, 19))
            0:          calm_left <= $urandom_range(50, 200);
            1, 2, 3, 4: stall_left <= $urandom_range(1, 7);
            default:    ;
         endcase
      end
   end

   always @(posedge clock) begin
      flow_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_line_valid, rsp_line_byte, rsp_read_valid, rsp_read_byte, rsp_accepted,
                rsp_rx_fill, rsp_tx_space, rsp_remote_stopped, rsp_tx_armed};
         if (pending_results.size() == 0) begin
            report_fault({"result beat with none expected: ", fmt_result(got)});
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               report_fault({"mismatch exp ", fmt_result(want), " got ", fmt_result(got)});
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_paths();
      test_xoff_xon_cycle();
      test_random_traffic();
      test_rx_overflow();
      test_tx_overflow();
      wait_drained();
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* uart_fifo_xon_xoff_flow_unit.f */
rtl/uxf_pkg.sv
rtl/uxf_ram.sv
rtl/uxf_ctrl.sv
rtl/uart_fifo_xon_xoff_flow_unit.sv
sim/tb_top.sv
